// ===== sv/irad_pkg.sv =====
// Shared types, constants and the digit-to-character mapping for the integer to radix
// ASCII converter. Used by irad_div and integer_to_radix_ascii; depends on nothing.
package irad_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
    localparam int IDX_W       = $clog2(VALUE_WIDTH);
    localparam int STEP_W      = $clog2(VALUE_WIDTH);
    localparam int RADIX_W     = 6;
    localparam int CH_W        = 7;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;

    localparam logic [CH_W-1:0] CH_NONE  = 7'h00;
    localparam logic [CH_W-1:0] CH_MINUS = 7'h2d;
    localparam logic [CH_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CH_W-1:0] CH_LOWA  = 7'h61;
    localparam logic [CH_W-1:0] CH_TEN   = 7'd10;

    typedef struct packed {
        logic signed [31:0]  value;
        logic [RADIX_W-1:0]  radix;
    } t_in_item;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            last;
        logic            empty_res;
    } t_out_item;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] quot;
        logic [RADIX_W-1:0]     rem;
    } t_div_res;

    function automatic logic [CH_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
        logic [CH_W-1:0] r;
        if (d < RADIX_DEC) begin
            r = CH_ZERO + CH_W'(d);
        end else begin
            r = CH_LOWA + CH_W'(d) - CH_TEN;
        end
        return r;
    endfunction

endpackage

// ===== sv/integer_to_radix_ascii.sv =====
// Top level of the integer to radix ASCII converter: sequencer, digit store and output.
// Depends on irad_pkg and instantiates irad_div.
//
// An item is taken when i_start is high and o_busy is low; o_busy stays high until the
// last character has been issued. Each digit costs one pass of the shared one-bit-a-cycle
// divider; a value has at most 32 digits, which a binary value can reach. Characters
// then leave one per cycle on o_result with o_strobe high for one cycle each, most
// significant first and a leading minus sign for a negative decimal value; the final
// one has last set. An invalid radix gives a single item with empty_res and last set.
// Results cannot be held off, so the receiver must take every strobed item.
module integer_to_radix_ascii (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  irad_pkg::t_in_item  i_item,
    output logic                o_busy,
    output logic                o_strobe,
    output irad_pkg::t_out_item o_result
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_INVAL = 6'b000010,
        S_DIVST = 6'b000100,
        S_DIVWT = 6'b001000,
        S_SIGN  = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state                           r_state, n_state;
    logic [irad_pkg::VALUE_WIDTH-1:0] r_quot, n_quot;
    logic [irad_pkg::RADIX_W-1:0]     r_radix, n_radix;
    logic                             r_minus, n_minus;
    logic [irad_pkg::CNT_W-1:0]       r_count, n_count;
    logic                             r_strobe, n_strobe;
    irad_pkg::t_out_item              r_res, n_res;
    logic [irad_pkg::RADIX_W-1:0]     r_rd;
    logic [irad_pkg::RADIX_W-1:0]     r_store [irad_pkg::VALUE_WIDTH];

    logic                             accept;
    logic [irad_pkg::VALUE_WIDTH-1:0] v_in;
    logic                             neg_dec;
    logic                             radix_ok;
    logic                             div_start;
    logic                             div_done;
    irad_pkg::t_div_res               div_res;
    logic [irad_pkg::CNT_W-1:0]       rd_sel;
    logic [irad_pkg::IDX_W-1:0]       rd_idx;

    irad_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_quot),
        .i_divisor  (r_radix),
        .o_done     (div_done),
        .o_res      (div_res)
    );

    assign accept    = i_start && (r_state == S_IDLE);
    assign v_in      = irad_pkg::VALUE_WIDTH'(i_item.value);
    assign radix_ok  = (i_item.radix >= irad_pkg::RADIX_MIN) &&
                       (i_item.radix <= irad_pkg::RADIX_MAX);
    assign neg_dec   = v_in[irad_pkg::VALUE_WIDTH-1] && (i_item.radix == irad_pkg::RADIX_DEC);
    assign div_start = (r_state == S_DIVST);
    assign rd_sel    = (r_state == S_SIGN) ? (r_count - 1'b1) : (r_count - 2'd2);
    assign rd_idx    = rd_sel[irad_pkg::IDX_W-1:0];

    always_comb begin
        n_state  = r_state;
        n_quot   = r_quot;
        n_radix  = r_radix;
        n_minus  = r_minus;
        n_count  = r_count;
        n_strobe = 1'b0;
        n_res    = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_radix = i_item.radix;
                    n_minus = neg_dec;
                    n_quot  = neg_dec ? (~v_in + 1'b1) : v_in;
                    n_count = '0;
                    n_state = radix_ok ? S_DIVST : S_INVAL;
                end
            end
            S_INVAL: begin
                n_strobe        = 1'b1;
                n_res.ch        = irad_pkg::CH_NONE;
                n_res.last      = 1'b1;
                n_res.empty_res = 1'b1;
                n_state         = S_IDLE;
            end
            S_DIVST: begin
                n_state = S_DIVWT;
            end
            S_DIVWT: begin
                if (div_done) begin
                    n_quot  = div_res.quot;
                    n_count = r_count + 1'b1;
                    n_state = (div_res.quot == '0) ? S_SIGN : S_DIVST;
                end
            end
            S_SIGN: begin
                if (r_minus) begin
                    n_strobe        = 1'b1;
                    n_res.ch        = irad_pkg::CH_MINUS;
                    n_res.last      = 1'b0;
                    n_res.empty_res = 1'b0;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                n_strobe        = 1'b1;
                n_res.ch        = irad_pkg::digit_to_ascii(r_rd);
                n_res.last      = (r_count == irad_pkg::CNT_W'(1));
                n_res.empty_res = 1'b0;
                n_count         = r_count - 1'b1;
                if (r_count == irad_pkg::CNT_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_quot   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_quot   <= n_quot;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_radix <= n_radix;
        r_minus <= n_minus;
        r_res   <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DIVWT) && div_done) begin
            r_store[r_count[irad_pkg::IDX_W-1:0]] <= div_res.rem;
        end
        r_rd <= r_store[rd_idx];
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_busy)
        else $error("Converter did not go busy after taking an item.");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.empty_res) |-> o_result.last)
        else $error("Empty result was not marked as the last item.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= irad_pkg::CNT_W'(irad_pkg::VALUE_WIDTH))
        else $error("Digit count exceeded the store depth.");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_res.last) |-> (r_state == S_IDLE))
        else $error("Converter still busy after issuing the last item.");
`endif

endmodule

// ===== sv/irad_div.sv =====
// Restoring divider that produces one quotient bit per cycle for the radix converter.
// Depends on irad_pkg for widths and the result struct.
module irad_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [irad_pkg::VALUE_WIDTH-1:0] i_dividend,
    input  logic [irad_pkg::RADIX_W-1:0]     i_divisor,
    output logic                             o_done,
    output irad_pkg::t_div_res               o_res
);

    logic                             r_run;
    logic                             r_done;
    logic [irad_pkg::STEP_W-1:0]      r_step;
    logic [irad_pkg::VALUE_WIDTH-1:0] r_quot;
    logic [irad_pkg::RADIX_W-1:0]     r_rem;
    logic [irad_pkg::RADIX_W-1:0]     r_dsr;
    logic [irad_pkg::RADIX_W:0]       shifted;
    logic                             ge;
    logic [irad_pkg::RADIX_W:0]       diff;

    assign shifted = {r_rem, r_quot[irad_pkg::VALUE_WIDTH-1]};
    assign ge      = shifted >= {1'b0, r_dsr};
    assign diff    = shifted - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_step <= '0;
            end else if (r_run) begin
                r_step <= r_step + 1'b1;
                if (r_step == irad_pkg::STEP_W'(irad_pkg::VALUE_WIDTH - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dsr  <= i_divisor;
        end else if (r_run) begin
            r_quot <= {r_quot[irad_pkg::VALUE_WIDTH-2:0], ge};
            r_rem  <= ge ? diff[irad_pkg::RADIX_W-1:0] : shifted[irad_pkg::RADIX_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_res.quot = r_quot;
    assign o_res.rem  = r_rem;

endmodule
